### src/multiprecision_byte_alu_macros.svh
// assertion macros shared by the multiprecision byte alu checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef MULTIPRECISION_BYTE_ALU_MACROS_SVH
`define MULTIPRECISION_BYTE_ALU_MACROS_SVH

// same-cycle implication
`define MPBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mpba_pkg.sv
// shared types and constants for the multiprecision byte alu
// no dependencies
`default_nettype none

package mpba_pkg;

    localparam int BYTE_BITS         = 8;
    localparam int DIVISOR_PORT_BITS = 16;
    localparam int REMAINDER_BITS    = 16;
    localparam int DIVISOR_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_DIV = 2'd2,
        ACT_NOP = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

### src/mpba_if.sv
// valid/ready channel interfaces for the multiprecision byte alu
// depends on mpba_pkg
`default_nettype none

interface mpba_in_if;
    import mpba_pkg::*;

    logic                         valid;
    logic                         ready;
    t_action                      action;
    logic                         first;
    logic [BYTE_BITS-1:0]         a_byte;
    logic [BYTE_BITS-1:0]         b_byte;
    logic [DIVISOR_PORT_BITS-1:0] divisor;

    modport source(output valid, action, first, a_byte, b_byte, divisor, input ready);
    modport sink(input valid, action, first, a_byte, b_byte, divisor, output ready);
endinterface

interface mpba_out_if;
    import mpba_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [BYTE_BITS-1:0]      result_byte;
    logic                      carry_out;
    logic [REMAINDER_BITS-1:0] remainder;

    modport source(output valid, result_byte, carry_out, remainder, input ready);
    modport sink(input valid, result_byte, carry_out, remainder, output ready);
endinterface

`default_nettype wire

### src/multiprecision_byte_alu.sv
// byte-serial add, subtract and divide-by-small-integer unit, one bit per cycle unless a full output stalls
// the result is written to the output register by the step that processes the last bit of the byte
// the bit-serial shift of a byte must finish before the next transaction can start
// a new input is taken in the cycle the previous byte finishes; a full output stalls the last bit
// reset (synchronous, active low) clears carry, remainder, sequencer and output valid
// depends on mpba_pkg and mpba_if
`default_nettype none

module multiprecision_byte_alu #(
    parameter int DIVISOR_BITS = mpba_pkg::DIVISOR_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpba_in_if.sink   i_in,
    mpba_out_if.source o_out
);
    import mpba_pkg::*;

    localparam int                  CNT_BITS = $clog2(BYTE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(BYTE_BITS - 1);

    t_state                    r_state, n_state;
    logic [CNT_BITS-1:0]       r_cnt;
    t_action                   r_op;
    logic [BYTE_BITS-1:0]      r_a, n_a;
    logic [BYTE_BITS-1:0]      r_b, n_b;
    logic [BYTE_BITS-1:0]      r_q, n_q;
    logic [DIVISOR_BITS-1:0]   r_div;
    logic [DIVISOR_BITS-1:0]   r_rem, n_rem;
    logic                      r_carry, n_carry;
    logic                      r_out_valid;
    logic [BYTE_BITS-1:0]      r_out_result;
    logic                      r_out_carry;
    logic [REMAINDER_BITS-1:0] r_out_rem;

    logic                    out_free, last, step, finish, accept;
    logic                    sum_bit, add_c, sub_c, rem_ge;
    logic [DIVISOR_BITS:0]   rem_sh, div_ext, rem_diff;
    logic                    carry_now;
    logic [DIVISOR_BITS-1:0] rem_now;

    assign out_free   = !r_out_valid || o_out.ready;
    assign last       = (r_cnt == CNT_LAST);
    assign step       = (r_state == ST_RUN) && (!last || out_free);
    assign finish     = step && last;
    assign i_in.ready = (r_state == ST_IDLE) || finish;
    assign accept     = i_in.valid && i_in.ready;

    // bit-serial add and subtract cells
    assign sum_bit = r_a[0] ^ r_b[0] ^ r_carry;
    assign add_c   = (r_a[0] & r_b[0]) | (r_carry & (r_a[0] ^ r_b[0]));
    assign sub_c   = (~r_a[0] & r_b[0]) | (r_carry & ~(r_a[0] ^ r_b[0]));

    // one restoring division step
    assign rem_sh   = {r_rem, r_b[BYTE_BITS-1]};
    assign div_ext  = {1'b0, r_div};
    assign rem_ge   = (rem_sh >= div_ext);
    assign rem_diff = rem_sh - div_ext;

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_q     = r_q;
        n_rem   = r_rem;
        n_carry = r_carry;
        unique case (r_op)
            ACT_ADD: begin
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_q     = {sum_bit, r_q[BYTE_BITS-1:1]};
                n_carry = add_c;
            end
            ACT_SUB: begin
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_q     = {sum_bit, r_q[BYTE_BITS-1:1]};
                n_carry = sub_c;
            end
            ACT_DIV: begin
                n_b   = r_b << 1;
                n_q   = {r_q[BYTE_BITS-2:0], rem_ge};
                n_rem = rem_ge ? rem_diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
            end
            ACT_NOP: begin
            end
            default: begin
            end
        endcase
    end

    assign carry_now = step ? n_carry : r_carry;
    assign rem_now   = step ? n_rem : r_rem;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (finish && !accept) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= 1'b0;
            r_rem   <= '0;
        end else if (accept) begin
            r_carry <= i_in.first ? 1'b0 : carry_now;
            r_rem   <= i_in.first ? '0 : rem_now;
        end else begin
            r_carry <= carry_now;
            r_rem   <= rem_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in.action;
            r_a   <= i_in.a_byte;
            r_b   <= i_in.b_byte;
            r_div <= DIVISOR_BITS'(i_in.divisor);
            r_q   <= '0;
            r_cnt <= '0;
        end else if (step) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_q   <= n_q;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_result <= n_q;
            r_out_carry  <= (r_op == ACT_DIV) ? 1'b0 : n_carry;
            r_out_rem    <= REMAINDER_BITS'(n_rem);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_byte = r_out_result;
    assign o_out.carry_out   = r_out_carry;
    assign o_out.remainder   = r_out_rem;

endmodule

`default_nettype wire

### src/mpba_checker.sv
// port-level checks for the multiprecision byte alu, bound to the top level
// depends on multiprecision_byte_alu_macros.svh and multiprecision_byte_alu
`default_nettype none
`include "multiprecision_byte_alu_macros.svh"

module mpba_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a stalled result stays offered
    `MPBA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")

    // the unit is busy right after taking a transaction
    `MPBA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready,
        "input ready right after accept")

    // a fresh result only comes out of a busy sequencer
    `MPBA_ASSERT_SAME(a_result_from_work, $rose(i_out_valid), $past(!i_in_ready, 2),
        "result without work in progress")

endmodule

bind multiprecision_byte_alu mpba_checker u_mpba_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready)
);

`default_nettype wire
